### sv/ebra_pkg.sv
// Shared constants, request codes and types for the embedding bag row average block.
// No dependencies; imported by every module of the block.
package ebra_pkg;

  localparam int TABLE_ROWS = 1024;
  localparam int MAX_COLS   = 64;
  localparam int MAX_BAG    = 255;

  localparam int WEIGHT_W = 16;
  localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_AW   = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
  localparam int TAB_AW   = ROW_AW + COL_W;
  localparam int TAB_DEPTH = 1 << TAB_AW;
  localparam int COUNT_W  = $clog2(MAX_BAG + 1);
  // column sums of up to MAX_BAG Q4.12 words
  localparam int ACC_W    = WEIGHT_W + COUNT_W;
  localparam int DIV_CNT_W = $clog2(ACC_W + 1);

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic [ACC_W-1:0] data;
  } acc_wr_t;

endpackage

### sv/ebra_wtab.sv
// Weight table: element-wide synchronous RAM, one write and one registered read port.
// Depends on ebra_pkg.
module ebra_wtab import ebra_pkg::*; (
  input  logic                clk,
  input  logic                we,
  input  logic [TAB_AW-1:0]   waddr,
  input  logic [WEIGHT_W-1:0] wdata,
  input  logic                re,
  input  logic [TAB_AW-1:0]   raddr,
  output logic [WEIGHT_W-1:0] q
);

  logic [WEIGHT_W-1:0] mem [TAB_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q <= mem[raddr];
    end
  end

endmodule

### sv/ebra_acc.sv
// Column accumulator RAM with per-entry valid bits; an invalid entry reads as zero.
// Depends on ebra_pkg (acc_wr_t, widths).
module ebra_acc import ebra_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  acc_wr_t          wr,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  input  logic             clr,
  output logic [ACC_W-1:0] q
);

  logic [ACC_W-1:0]    mem [MAX_COLS];
  logic [MAX_COLS-1:0] vld;
  logic [ACC_W-1:0]    rd_data;
  logic                rd_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_vld  <= vld[rd_addr];
    end
  end

  // clear-all after a finish
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  assign q = rd_vld ? rd_data : '0;

endmodule

### sv/ebra_div.sv
// Signed-by-unsigned restoring divider, one quotient bit per cycle, truncates toward zero.
// Depends on ebra_pkg (ACC_W, COUNT_W, DIV_CNT_W).
module ebra_div import ebra_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [ACC_W-1:0]   dividend,
  input  logic [COUNT_W-1:0] divisor,
  output logic               done,
  output logic [ACC_W-1:0]   quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [ACC_W-1:0]     work;
  logic [COUNT_W-1:0]   rem;
  logic [COUNT_W-1:0]   den;
  logic                 neg;
  logic [COUNT_W:0]     shifted;
  logic [COUNT_W:0]     diff;
  logic                 ge;

  assign shifted = {rem, work[ACC_W-1]};
  assign diff    = shifted - {1'b0, den};
  assign ge      = !diff[COUNT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == DIV_CNT_W'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[ACC_W-1];
      work <= dividend[ACC_W-1] ? (~dividend + 1'b1) : dividend;
      rem  <= '0;
      den  <= divisor;
      cnt  <= DIV_CNT_W'(ACC_W);
    end else if (busy) begin
      rem  <= ge ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
      work <= {work[ACC_W-2:0], ge};
      cnt  <= cnt - 1'b1;
    end
  end

  assign quotient = neg ? (~work + 1'b1) : work;

endmodule

### sv/embedding_bag_row_average.sv
// Top level of the embedding bag row average block: control sequencer and result register.
// Depends on ebra_pkg, ebra_wtab, ebra_acc, ebra_div.
//
//  port group | dir | payload                                         | beat taken when
//  s_axis     | in  | tuser: req_type; tdata: row, col, weight        | tvalid & tready
//  m_axis     | out | tdata: avg_value, out_column; tlast; tuser flags | tvalid & tready
//  cfg        | in  | cfg_data: cols_in_use                           | cfg_valid & cfg_ready
//
// Sequencing: a table write, an ignored or unknown request is handled in S_IDLE without
// leaving it. An add walks all MAX_COLS columns through the table and accumulator RAMs,
// one column per cycle, then passes S_ADDW. A finish steps each emitted column through
// S_FRD, S_FSTART, the one-bit-per-cycle divider in S_FDIV (skipped for an empty bag)
// and S_FOUT, where any m_axis backpressure holds it.
// Reset: rst (synchronous) clears control, counters and accumulator valid bits at once;
// the weight table holds whatever was last written. cols_in_use resets to MAX_COLS.
// Stalls: s_axis_tready is low through an add walk and a finish; a held m_axis stalls the
// finish at each column. The last beat waits in the output register while the next
// request is taken.
module embedding_bag_row_average import ebra_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // row_index[9:0], col_index[15:10], weight_value[31:16]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // avg_value[15:0], out_column[21:16], zero[23:22]
  output logic        m_axis_tlast,   // is_last
  output logic [1:0]  m_axis_tuser,   // empty_bag[0], count_saturated[1]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data        // cols_in_use
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ADD    = 7'b0000010,
    S_ADDW   = 7'b0000100,
    S_FRD    = 7'b0001000,
    S_FSTART = 7'b0010000,
    S_FDIV   = 7'b0100000,
    S_FOUT   = 7'b1000000
  } state_t;

  state_t state;

  // input fields
  logic [1:0]                 req_type;
  logic [9:0]                 row_index;
  logic [5:0]                 col_index;
  logic signed [WEIGHT_W-1:0] weight_value;

  assign req_type     = s_axis_tuser;
  assign row_index    = s_axis_tdata[9:0];
  assign col_index    = s_axis_tdata[15:10];
  assign weight_value = s_axis_tdata[31:16];

  logic               in_acc;
  logic               row_ok;
  logic               col_ok;

  // control registers
  logic [6:0]         cols_in_use;
  logic [COL_W-1:0]   col_cnt;
  logic [ROW_AW-1:0]  row_sel;
  logic [COUNT_W-1:0] bag_count;
  logic               overflow_seen;
  logic [COL_W-1:0]   n_last;
  logic [COL_W-1:0]   n_last_next;
  logic               fin_empty;
  logic               fin_sat;
  logic [COUNT_W-1:0] div_den;
  logic               wb_valid;
  logic [COL_W-1:0]   wb_col;

  // output register
  logic               out_valid;
  logic [WEIGHT_W-1:0] out_avg;
  logic [5:0]         out_col;
  logic               out_last;
  logic               out_empty;
  logic               out_sat;

  // RAM and divider hookup
  logic               wt_we;
  logic [TAB_AW-1:0]  wt_waddr;
  logic [TAB_AW-1:0]  wt_raddr;
  logic [WEIGHT_W-1:0] wt_q;
  acc_wr_t            acc_wr;
  logic               acc_rd_en;
  logic               acc_clr;
  logic [ACC_W-1:0]   acc_q;
  logic               div_start;
  logic               div_done;
  logic [ACC_W-1:0]   div_quo;
  logic               out_load;
  logic               fin_last;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign row_ok        = int'(row_index) < TABLE_ROWS;
  assign col_ok        = int'(col_index) < MAX_COLS;

  // cols_in_use of zero acts as one, above MAX_COLS as MAX_COLS
  always_comb begin
    if (cols_in_use == 7'd0) begin
      n_last_next = '0;
    end else if (int'(cols_in_use) > MAX_COLS) begin
      n_last_next = COL_W'(MAX_COLS - 1);
    end else begin
      n_last_next = COL_W'(cols_in_use - 7'd1);
    end
  end

  // table element writes go straight in from the accepted beat
  assign wt_we    = in_acc && (req_type == REQ_WRITE) && row_ok && col_ok;
  assign wt_waddr = {ROW_AW'(row_index), col_index[COL_W-1:0]};
  assign wt_raddr = {row_sel, col_cnt};

  ebra_wtab u_wtab (
    .clk   (clk),
    .we    (wt_we),
    .waddr (wt_waddr),
    .wdata (weight_value),
    .re    (state == S_ADD),
    .raddr (wt_raddr),
    .q     (wt_q)
  );

  // accumulate: read column c in one cycle, write it back the next; consecutive
  // columns differ, so the read and write ports never meet on one entry
  assign acc_wr.en   = wb_valid;
  assign acc_wr.addr = wb_col;
  assign acc_wr.data = acc_q + {{(ACC_W - WEIGHT_W){wt_q[WEIGHT_W-1]}}, wt_q};
  assign acc_rd_en   = (state == S_ADD) || (state == S_FRD);

  assign fin_last = (col_cnt == n_last);
  assign out_load = (state == S_FOUT) && (!out_valid || m_axis_tready);
  assign acc_clr  = out_load && fin_last;

  ebra_acc u_acc (
    .clk     (clk),
    .rst     (rst),
    .wr      (acc_wr),
    .rd_en   (acc_rd_en),
    .rd_addr (col_cnt),
    .clr     (acc_clr),
    .q       (acc_q)
  );

  assign div_start = (state == S_FSTART) && !fin_empty;

  ebra_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_q),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      col_cnt       <= '0;
      bag_count     <= '0;
      overflow_seen <= 1'b0;
      cols_in_use   <= 7'(MAX_COLS);
      wb_valid      <= 1'b0;
    end else begin
      wb_valid <= (state == S_ADD);
      wb_col   <= col_cnt;
      if (cfg_valid && cfg_ready) begin
        cols_in_use <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (req_type)
              REQ_ADD: begin
                if (row_ok && (bag_count != COUNT_W'(MAX_BAG))) begin
                  state     <= S_ADD;
                  col_cnt   <= '0;
                  row_sel   <= ROW_AW'(row_index);
                  bag_count <= bag_count + 1'b1;
                end else if (row_ok) begin
                  overflow_seen <= 1'b1;
                end
              end
              REQ_FINISH: begin
                state         <= S_FRD;
                col_cnt       <= '0;
                n_last        <= n_last_next;
                fin_empty     <= (bag_count == '0);
                fin_sat       <= overflow_seen;
                div_den       <= bag_count;
                bag_count     <= '0;
                overflow_seen <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_ADD: begin
          col_cnt <= col_cnt + 1'b1;
          if (col_cnt == COL_W'(MAX_COLS - 1)) begin
            state <= S_ADDW;
          end
        end
        S_ADDW: begin
          state <= S_IDLE;
        end
        S_FRD: begin
          state <= S_FSTART;
        end
        S_FSTART: begin
          state <= fin_empty ? S_FOUT : S_FDIV;
        end
        S_FDIV: begin
          if (div_done) begin
            state <= S_FOUT;
          end
        end
        S_FOUT: begin
          if (out_load) begin
            if (fin_last) begin
              state <= S_IDLE;
            end else begin
              col_cnt <= col_cnt + 1'b1;
              state   <= S_FRD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_avg   <= fin_empty ? '0 : div_quo[WEIGHT_W-1:0];
      out_col   <= 6'(col_cnt);
      out_last  <= fin_last;
      out_empty <= fin_empty;
      out_sat   <= fin_sat;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_col, out_avg};
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = {out_sat, out_empty};

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(bag_count) <= MAX_BAG)
    else $error("bag count beyond maximum");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[15:0] == 16'd0))
    else $error("empty bag result not zero");

  a_acc_write: assert property (@(posedge clk) disable iff (rst)
    acc_wr.en |-> $past(state == S_ADD))
    else $error("accumulator written outside an add walk");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_FDIV))
    else $error("divider finished outside divide wait");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD) |=> !in_acc)
    else $error("request taken during add walk");

endmodule

### tb/sv/embedding_bag_row_average_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for embedding_bag_row_average: table loads, bags and mean readout.
// Depends on ebra_pkg and the block's RTL; a shadow model of table and bag predicts each beat.
module embedding_bag_row_average_tb import ebra_pkg::*; ();

  // req_type 3 is undefined; the block must swallow it without output
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 3000;
  // an add walks every column, so a non-result request can still be busy this long
  localparam int QUIET_CYCLES = 2 * MAX_COLS + 10;
  localparam int PHASE_ITEMS = 4;

  // one output beat as seen on m_axis
  typedef struct packed {
    logic [15:0] avg;
    logic [5:0]  col;
    logic        last;
    logic        empty;
    logic        sat;
  } col_mean_t;

  // directed row: request plus an optional typed-in value for every column of a finish
  typedef struct packed {
    logic [1:0]  req;
    logic [9:0]  row;
    logic [5:0]  col;
    logic [15:0] w;
    logic        typed;
    logic [15:0] t_avg;
    logic        t_empty;
  } stim_t;

  // row 0 starts with every column at the weight minimum
  localparam stim_t DIRECTED [16] = '{
    '{REQ_FINISH,  10'd0,    6'd0,  16'h0000, 1'b1, 16'h0000, 1'b1}, // empty bag from reset
    '{REQ_ADD,     10'd0,    6'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{REQ_FINISH,  10'd0,    6'd0,  16'h0000, 1'b1, 16'h8000, 1'b0}, // row of all min
    '{REQ_ADD,     10'd0,    6'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{REQ_ADD,     10'd0,    6'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{REQ_FINISH,  10'd0,    6'd0,  16'h0000, 1'b1, 16'h8000, 1'b0}, // two min rows
    '{REQ_UNKNOWN, 10'd1023, 6'd63, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{REQ_UNKNOWN, 10'd5,    6'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{REQ_FINISH,  10'd0,    6'd0,  16'h0000, 1'b1, 16'h0000, 1'b1}, // still empty
    '{REQ_WRITE,   10'd0,    6'd0,  16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{REQ_ADD,     10'd0,    6'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{REQ_FINISH,  10'd0,    6'd0,  16'h0000, 1'b0, 16'h0000, 1'b0}, // column 0 at max
    '{REQ_ADD,     10'd0,    6'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{REQ_WRITE,   10'd0,    6'd0,  16'h8000, 1'b0, 16'h0000, 1'b0}, // rewrite mid-bag
    '{REQ_ADD,     10'd0,    6'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{REQ_FINISH,  10'd0,    6'd0,  16'h0000, 1'b0, 16'h0000, 1'b0}  // column 0: -1/2
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;    // row_index[9:0], col_index[15:10], weight_value[31:16]
  logic [1:0]  s_axis_tuser = '0;    // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // avg_value[15:0], out_column[21:16], zero[23:22]
  logic        m_axis_tlast;         // is_last
  logic [1:0]  m_axis_tuser;         // empty_bag[0], count_saturated[1]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;        // cols_in_use

  // shadow of the block: weight table, column sums, bag count, overflow, column count
  logic signed [15:0]  shadow_weights [TABLE_ROWS][MAX_COLS];
  logic [MAX_COLS-1:0] row_written [TABLE_ROWS];
  int                  loaded_rows[$];   // rows safe to add: every column written
  int                  col_sum [MAX_COLS];
  int                  bag_rows = 0;
  bit                  bag_overflow = 1'b0;
  int                  cols_setting = MAX_COLS;
  col_mean_t           pending_means[$]; // beats still owed by the block

  int mismatches = 0;
  int cycles = 0;
  bit calm = 1'b0;      // no idling on either side while set
  bit hold_arm = 1'b0;  // asks the sink for its one long hold-off
  bit hold_done = 1'b0;
  int hold_left = 0;

  embedding_bag_row_average dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // sink: random stalls, plus one long hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 32);
    end
  end

  task automatic note_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 200)
      $display("MISMATCH %s: got %0d, want %0d (cycle %0d)", what, got, want, cycles);
  endtask

  // output beats: each one is checked against the oldest owed mean
  always @(posedge clk) begin
    col_mean_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[15:0], m_axis_tdata[21:16], m_axis_tlast,
              m_axis_tuser[0], m_axis_tuser[1]};
      if (pending_means.size() == 0) begin
        note_mismatch("unexpected beat, column", got.col, -1);
      end else begin
        want = pending_means.pop_front();
        if (got.avg !== want.avg)
          note_mismatch("avg_value", $signed(got.avg), $signed(want.avg));
        if (got.col !== want.col) note_mismatch("out_column", got.col, want.col);
        if (got.last !== want.last) note_mismatch("is_last", got.last, want.last);
        if (got.empty !== want.empty) note_mismatch("empty_bag", got.empty, want.empty);
        if (got.sat !== want.sat) note_mismatch("count_saturated", got.sat, want.sat);
      end
    end
  end

  // Apply one accepted request to the shadow state; a finish queues one mean per column.
  // A typed finish replaces the computed value and empty flag with the ones given.
  task automatic track_request(input logic [1:0] req, input logic [9:0] row,
                               input logic [5:0] col, input logic [15:0] w,
                               input bit typed, input logic [15:0] t_avg, input bit t_empty);
    int n;
    col_mean_t beat;
    case (req)
      REQ_WRITE: begin
        shadow_weights[row][col] = w;
        if (!(&row_written[row])) begin
          row_written[row][col] = 1'b1;
          if (&row_written[row]) loaded_rows.insert(loaded_rows.size(), int'(row));
        end
      end
      REQ_ADD: begin
        if (bag_rows >= MAX_BAG) begin
          bag_overflow = 1'b1;
        end else begin
          for (int c = 0; c < MAX_COLS; c++) col_sum[c] += shadow_weights[row][c];
          bag_rows++;
        end
      end
      REQ_FINISH: begin
        n = (cols_setting == 0) ? 1 : (cols_setting > MAX_COLS) ? MAX_COLS : cols_setting;
        for (int c = 0; c < n; c++) begin
          beat.avg   = (bag_rows == 0) ? 16'h0000 : 16'(col_sum[c] / bag_rows);
          beat.col   = 6'(c);
          beat.last  = (c == n - 1);
          beat.empty = (bag_rows == 0);
          beat.sat   = bag_overflow;
          if (typed) begin
            beat.avg   = t_avg;
            beat.empty = t_empty;
          end
          pending_means.insert(pending_means.size(), beat);
        end
        for (int c = 0; c < MAX_COLS; c++) col_sum[c] = 0;
        bag_rows = 0;
        bag_overflow = 1'b0;
      end
      default: ;
    endcase
  endtask

  // Offer one beat, with random idle cycles ahead of it; valid stays high on return.
  task automatic send_req(input logic [1:0] req, input logic [9:0] row,
                          input logic [5:0] col, input logic [15:0] w,
                          input bit typed = 1'b0, input logic [15:0] t_avg = '0,
                          input bit t_empty = 1'b0);
    while (!calm && $urandom_range(99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w, col, row};
    s_axis_tuser  <= req;
    do @(posedge clk); while (!s_axis_tready);
    track_request(req, row, col, w, typed, t_avg, t_empty);
  endtask

  // Drop valid, wait for every owed beat, then let a trailing add finish.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_cols(input logic [6:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cols_setting = v;
  endtask

  function automatic int pick_loaded();
    return loaded_rows[$urandom_range(loaded_rows.size() - 1)];
  endfunction

  // Mostly short well-formed bags of loaded rows, with writes, stray codes mixed in,
  // always closed by a finish so the phase ends idle.
  task automatic random_phase(input int n_items);
    int done;
    int pick;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        if ($urandom_range(9) < 6)
          send_req(REQ_WRITE, 10'(pick_loaded()), 6'($urandom_range(63)),
                   16'($urandom_range(65535)));
        else
          send_req(REQ_WRITE, 10'($urandom_range(1023)), 6'($urandom_range(63)),
                   16'($urandom_range(65535)));
        done++;
      end else if (pick < 70) begin
        send_req(REQ_ADD, 10'(pick_loaded()), 6'($urandom_range(63)),
                 16'($urandom_range(65535)));
        done++;
      end else if (pick < 92) begin
        send_req(REQ_FINISH, 10'($urandom_range(1023)), 6'($urandom_range(63)),
                 16'($urandom_range(65535)));
        done++;
      end else begin
        send_req(REQ_UNKNOWN, 10'($urandom_range(1023)), 6'($urandom_range(63)),
                 16'($urandom_range(65535)));
      end
    end
    send_req(REQ_FINISH, '0, '0, '0);
    settle();
  endtask

  initial begin
    logic [6:0] phase_cols [5];
    for (int r = 0; r < TABLE_ROWS; r++) row_written[r] = '0;
    for (int c = 0; c < MAX_COLS; c++) col_sum[c] = 0;
    phase_cols = '{7'd0, 7'd127, 7'd64, 7'd33, 7'($urandom_range(1, 64))};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // load row 0 whole, at the weight minimum, before anything reads it
    for (int c = 0; c < MAX_COLS; c++)
      send_req(REQ_WRITE, 10'd0, 6'(c), 16'h8000);

    // directed table at the reset column count
    foreach (DIRECTED[i])
      send_req(DIRECTED[i].req, DIRECTED[i].row, DIRECTED[i].col, DIRECTED[i].w,
               DIRECTED[i].typed, DIRECTED[i].t_avg, DIRECTED[i].t_empty);
    settle();

    // full bag: fill to the limit, then two adds that must be dropped and flagged
    write_cols(7'd1);
    for (int i = 0; i < MAX_BAG + 2; i++)
      send_req(REQ_ADD, 10'(pick_loaded()), '0, '0);
    send_req(REQ_FINISH, '0, '0, '0);
    settle();

    // random phases, one column count each, out-of-range settings included
    foreach (phase_cols[p]) begin
      write_cols(phase_cols[p]);
      calm = (phase_cols[p] == 7'd64);
      if (phase_cols[p] == 7'd33) begin
        hold_arm <= 1'b1;
        // a finish right away, so its beats back up behind the held sink
        send_req(REQ_ADD, 10'(pick_loaded()), '0, '0);
        send_req(REQ_FINISH, '0, '0, '0);
      end
      random_phase(PHASE_ITEMS);
      calm = 1'b0;
    end

    if (mismatches == 0 && pending_means.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
sv/ebra_pkg.sv
sv/ebra_wtab.sv
sv/ebra_acc.sv
sv/ebra_div.sv
sv/embedding_bag_row_average.sv
tb/sv/embedding_bag_row_average_tb.sv
